/* rtl/i2a_pkg.sv */
// Shared types, constants and helpers for the integer to ASCII digit converter.
package i2a_pkg;

  localparam int VALUE_W  = 64;
  localparam int NUM_CELLS = 20;  // one digit cell per decimal digit of a 64-bit value
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 8;
  localparam int WIDTH_W  = 5;

  localparam logic [WIDTH_W-1:0] MAX_DEC_DIGITS = 5'd20;
  localparam logic [WIDTH_W-1:0] MAX_HEX_DIGITS = 5'd16;

  // request modes; code 3 falls back to unsigned decimal
  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_CONV,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     serial_bit;  // next magnitude bit, MSB first, into the lowest cell
  } chain_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DEC_RADIX) begin
      digit_char = CH_ZERO + dw;
    end else begin
      digit_char = CH_UPPER_A + dw - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_RADIX};
    end
  endfunction

endpackage

/* rtl/i2a_cell.sv */
// One digit cell: holds a BCD or hex digit; loads it, does a shift-add-3 step or a plain shift.
module i2a_cell import i2a_pkg::*; (
  input  logic               clk,
  input  cell_op_t           op,
  input  logic [DIGIT_W-1:0] load_digit,
  input  logic               carry_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry_out
);

  logic [DIGIT_W-1:0] adj;
  logic [DIGIT_W-1:0] digit_next;

  // add 3 when the digit would overflow past 9 on doubling
  assign adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adj[DIGIT_W-1];

  always_comb begin
    unique case (op)
      OP_LOAD:  digit_next = load_digit;
      OP_CONV:  digit_next = {adj[DIGIT_W-2:0], carry_in};
      OP_SHIFT: digit_next = digit_in;
      default:  digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

/* rtl/i2a_chain.sv */
// Row of digit cells; bits ripple up during conversion, digits move up during output.
module i2a_chain import i2a_pkg::*; (
  input  logic                         clk,
  input  chain_ctrl_t                  ctrl,
  input  logic [NUM_CELLS*DIGIT_W-1:0] load_word,
  output logic [DIGIT_W-1:0]           top_digit
);

  logic [DIGIT_W-1:0] digits [NUM_CELLS];
  logic [NUM_CELLS:0] carry;

  assign carry[0] = ctrl.serial_bit;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [DIGIT_W-1:0] below;
    if (i == 0) begin : g_bottom
      assign below = '0;
    end else begin : g_inner
      assign below = digits[i-1];
    end

    i2a_cell u_cell (
      .clk        (clk),
      .op         (ctrl.op),
      .load_digit (load_word[i*DIGIT_W +: DIGIT_W]),
      .carry_in   (carry[i]),
      .digit_in   (below),
      .digit      (digits[i]),
      .carry_out  (carry[i+1])
    );
  end

  // the top cell never carries out: 20 digits hold any 64-bit value
  assign top_digit = digits[NUM_CELLS-1] | {DIGIT_W{carry[NUM_CELLS] & 1'b0}};

endmodule

/* rtl/integer_to_ascii_digits_core.sv */
// Top level of the integer to ASCII digit converter.
//
// Input channel (in_valid / in_stall): one item carries req_type, value,
// pad_char and min_width. An item is taken at a clock edge with in_valid
// high and in_stall low. in_stall stays high while an item is being worked.
// Output channel (out_valid / out_stall): one item per character, ch and last,
// most significant character first; last marks the final digit.
// Signed decimal starts with '+' or '-', then pad characters, then digits.
//
// Steps of one item: the accept cycle; for decimal, the double-dabble pass, one
// magnitude bit into the cell row per cycle (hex loads nibbles at accept); then
// leading zeros are dropped one per cycle; then the characters go out one per
// cycle while the receiver does not stall; leaving the pad phase is a step of
// its own.
// A new item is accepted once the final character sits in the output register.
// Reset (rst, synchronous) returns to idle and drops any pending character.
// When the receiver stalls, the character held in the output register stays
// put and the converter waits; nothing is lost.
module integer_to_ascii_digits_core import i2a_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [VALUE_W-1:0]   value,
  input  logic [CHAR_W-1:0]    pad_char,
  input  logic [WIDTH_W-1:0]   min_width,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    ch,
  output logic                 last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_PAD,
    ST_DIGITS
  } state_t;

  state_t               state;
  logic [VALUE_W-1:0]   mag;        // magnitude, shifted out MSB first
  logic [5:0]           bit_cnt;    // conversion steps left
  logic [WIDTH_W-1:0]   ndig;       // digits still in the row above the leading zeros
  logic [WIDTH_W-1:0]   width;      // clamped minimum width
  logic [WIDTH_W-1:0]   pads;       // pad characters left
  logic [CHAR_W-1:0]    pad;
  logic [CHAR_W-1:0]    sign_ch;
  logic                 has_sign;

  logic                 in_accept;
  logic                 out_free;
  logic                 emit_char;  // a character goes into the output register
  logic                 out_valid_next;
  logic                 is_hex;
  logic [VALUE_W-1:0]   in_mag;
  logic [WIDTH_W-1:0]   in_width;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 skip_zero;
  chain_ctrl_t          ctrl;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign emit_char = out_free && ((state == ST_SIGN) ||
                                  (state == ST_PAD && pads != '0) ||
                                  (state == ST_DIGITS));
  // held while stalled, refilled or emptied once taken
  assign out_valid_next = emit_char || (out_valid && out_stall);

  assign is_hex = (req_type == MODE_HEX);
  assign in_mag = (req_type == MODE_SDEC && value[VALUE_W-1]) ? (~value) + 1'b1 : value;

  always_comb begin
    if (is_hex) begin
      in_width = (min_width > MAX_HEX_DIGITS) ? MAX_HEX_DIGITS : min_width;
    end else begin
      in_width = (min_width > MAX_DEC_DIGITS) ? MAX_DEC_DIGITS : min_width;
    end
  end

  // a leading zero is dropped while more than one digit remains
  assign skip_zero = (top_digit == '0) && (ndig > 5'd1);

  always_comb begin
    ctrl.serial_bit = mag[VALUE_W-1];
    ctrl.op         = OP_HOLD;
    case (state)
      ST_IDLE:   if (in_accept) ctrl.op = OP_LOAD;
      ST_CONV:   ctrl.op = OP_CONV;
      ST_SKIP:   if (skip_zero) ctrl.op = OP_SHIFT;
      ST_DIGITS: if (out_free) ctrl.op = OP_SHIFT;
      default:   ctrl.op = OP_HOLD;
    endcase
  end

  i2a_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    // hex loads nibbles straight into the cells; decimal starts from zero
    .load_word (is_hex ? {{(NUM_CELLS*DIGIT_W-VALUE_W){1'b0}}, in_mag}
                       : {(NUM_CELLS*DIGIT_W){1'b0}}),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            mag      <= in_mag;
            bit_cnt  <= 6'd63;
            ndig     <= WIDTH_W'(NUM_CELLS);
            width    <= in_width;
            pad      <= pad_char;
            has_sign <= (req_type == MODE_SDEC);
            sign_ch  <= value[VALUE_W-1] ? CH_MINUS : CH_PLUS;
            state    <= is_hex ? ST_SKIP : ST_CONV;
          end
        end
        ST_CONV: begin
          mag     <= {mag[VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - 6'd1;
          if (bit_cnt == '0) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            ndig <= ndig - 5'd1;
          end else begin
            pads  <= (width > ndig) ? width - ndig : '0;
            state <= has_sign ? ST_SIGN : ST_PAD;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            ch    <= sign_ch;
            last  <= 1'b0;
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (pads == '0) begin
            state <= ST_DIGITS;
          end else if (out_free) begin
            ch   <= pad;
            last <= 1'b0;
            pads <= pads - 5'd1;
          end
        end
        ST_DIGITS: begin
          if (out_free) begin
            ch   <= digit_char(top_digit);
            last <= (ndig == 5'd1);
            ndig <= ndig - 5'd1;
            if (ndig == 5'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
